// ===== rtl/vskt_pkg.sv =====
`timescale 1ns / 1ps
// Package for the value-sorted key table: sizes, action and status codes,
// and the entry, memory request and result types. No dependencies.
package vskt_pkg;

  localparam int CAPACITY  = 64;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int KEY_W     = 16;
  localparam int VAL_W     = 32;
  localparam int ACT_W     = 2;
  localparam int STAT_W    = 2;
  localparam int OUT_CNT_W = 7;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE    = 2'd0,
    ST_PRESENT = 2'd1,
    ST_FULL    = 2'd2,
    ST_ABSENT  = 2'd3
  } status_e;

  typedef struct packed {
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] value;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic                    found;
    logic signed [VAL_W-1:0] value_out;
    logic [STAT_W-1:0]       status;
    logic [OUT_CNT_W-1:0]    entry_count;
  } result_t;

endpackage

// ===== rtl/vskt_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the value-sorted key table.
// Depends on vskt_pkg for field widths.
interface vskt_in_if;
  logic                             valid;
  logic                             ready;
  logic [vskt_pkg::ACT_W-1:0]       action;
  logic [vskt_pkg::KEY_W-1:0]       key;
  logic signed [vskt_pkg::VAL_W-1:0] value;

  modport source (output valid, action, key, value, input ready);
  modport sink   (input valid, action, key, value, output ready);
endinterface

interface vskt_out_if;
  logic                               valid;
  logic                               ready;
  logic                               found;
  logic signed [vskt_pkg::VAL_W-1:0]  value_out;
  logic [vskt_pkg::STAT_W-1:0]        status;
  logic [vskt_pkg::OUT_CNT_W-1:0]     entry_count;

  modport source (output valid, found, value_out, status, entry_count, input ready);
  modport sink   (input valid, found, value_out, status, entry_count, output ready);
endinterface

// ===== rtl/vskt_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vskt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/vskt_seq.sv =====
`timescale 1ns / 1ps
// Sequencer and shared compare unit of the value-sorted key table: scans the
// entry memory, then shifts entries up or down one slot per cycle.
// Depends on vskt_pkg and vskt_if.
module vskt_seq (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  vskt_in_if.sink                         in_i,
  input  logic signed [vskt_pkg::VAL_W-1:0] missing_value_i,
  output vskt_pkg::ram_req_t              ram_req_o,
  input  vskt_pkg::entry_t                ram_rdata_i,
  output logic                            res_valid_o,
  input  logic                            res_ready_i,
  output vskt_pkg::result_t               res_o
);

  localparam int IDX_W = vskt_pkg::IDX_W;
  localparam int CNT_W = vskt_pkg::CNT_W;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_SEARCH   = 6'b000010,
    S_SHIFT_UP = 6'b000100,
    S_PLACE    = 6'b001000,
    S_SHIFT_DN = 6'b010000,
    S_DONE     = 6'b100000
  } state_e;

  state_e                            state_q, state_d;
  vskt_pkg::action_e                 action_q, action_d;
  logic [vskt_pkg::KEY_W-1:0]        key_q, key_d;
  logic signed [vskt_pkg::VAL_W-1:0] value_q, value_d;
  logic signed [vskt_pkg::VAL_W-1:0] hit_val_q, hit_val_d;
  logic [CNT_W-1:0]                  count_q, count_d;
  logic [CNT_W-1:0]                  idx_q, idx_d;
  logic [CNT_W-1:0]                  pos_q, pos_d;
  logic [CNT_W-1:0]                  sh_q, sh_d;
  logic [CNT_W-1:0]                  sh_m1;
  logic                              pend_q, pend_d;
  logic [IDX_W-1:0]                  pend_idx_q, pend_idx_d;
  logic                              found_q, found_d;
  logic                              posf_q, posf_d;
  logic [IDX_W-1:0]                  slot_q, slot_d;
  vskt_pkg::status_e                 status_q, status_d;
  logic                              issue;

  assign sh_m1 = sh_q - CNT_W'(1);

  always_comb begin
    state_d    = state_q;
    action_d   = action_q;
    key_d      = key_q;
    value_d    = value_q;
    hit_val_d  = hit_val_q;
    count_d    = count_q;
    idx_d      = idx_q;
    pos_d      = pos_q;
    sh_d       = sh_q;
    pend_d     = pend_q;
    pend_idx_d = pend_idx_q;
    found_d    = found_q;
    posf_d     = posf_q;
    slot_d     = slot_q;
    status_d   = status_q;
    issue      = 1'b0;
    in_i.ready = 1'b0;
    res_valid_o = 1'b0;
    ram_req_o.we    = 1'b0;
    ram_req_o.waddr = pend_idx_q;
    ram_req_o.wdata = ram_rdata_i;
    ram_req_o.raddr = idx_q[IDX_W-1:0];

    case (state_q)
      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          action_d = vskt_pkg::action_e'(in_i.action);
          key_d    = in_i.key;
          value_d  = in_i.value;
          idx_d    = '0;
          pend_d   = 1'b0;
          found_d  = 1'b0;
          posf_d   = 1'b0;
          pos_d    = count_q;
          state_d  = S_SEARCH;
        end
      end

      S_SEARCH: begin
        // read slot idx, compare it in the next cycle
        issue = (idx_q < count_q);
        if (pend_q) begin
          if (!found_q && ram_rdata_i.key == key_q) begin
            found_d   = 1'b1;
            slot_d    = pend_idx_q;
            hit_val_d = ram_rdata_i.value;
          end
          if (!posf_q && !(value_q < ram_rdata_i.value)) begin
            posf_d = 1'b1;
            pos_d  = CNT_W'(pend_idx_q);
          end
        end
        if (issue) begin
          idx_d      = idx_q + CNT_W'(1);
          pend_d     = 1'b1;
          pend_idx_d = idx_q[IDX_W-1:0];
        end else begin
          pend_d = 1'b0;
        end
        if (!issue && !pend_q) begin
          case (action_q)
            vskt_pkg::ACT_LOOKUP: begin
              status_d = found_q ? vskt_pkg::ST_DONE : vskt_pkg::ST_ABSENT;
              state_d  = S_DONE;
            end
            vskt_pkg::ACT_INSERT: begin
              if (found_q) begin
                status_d = vskt_pkg::ST_PRESENT;
                state_d  = S_DONE;
              end else if (count_q == CNT_W'(vskt_pkg::CAPACITY)) begin
                status_d = vskt_pkg::ST_FULL;
                state_d  = S_DONE;
              end else begin
                status_d = vskt_pkg::ST_DONE;
                sh_d     = count_q;
                state_d  = S_SHIFT_UP;
              end
            end
            vskt_pkg::ACT_DELETE: begin
              if (found_q) begin
                status_d = vskt_pkg::ST_DONE;
                sh_d     = CNT_W'(slot_q) + CNT_W'(1);
                state_d  = S_SHIFT_DN;
              end else begin
                status_d = vskt_pkg::ST_ABSENT;
                state_d  = S_DONE;
              end
            end
            default: begin
              status_d = vskt_pkg::ST_DONE;
              count_d  = '0;
              state_d  = S_DONE;
            end
          endcase
        end
      end

      S_SHIFT_UP: begin
        // read slot sh-1, write it to slot sh next cycle
        ram_req_o.raddr = sh_m1[IDX_W-1:0];
        ram_req_o.we    = pend_q;
        issue = (sh_q > pos_q);
        if (issue) begin
          pend_d     = 1'b1;
          pend_idx_d = sh_q[IDX_W-1:0];
          sh_d       = sh_m1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            state_d = S_PLACE;
          end
        end
      end

      S_PLACE: begin
        ram_req_o.we        = 1'b1;
        ram_req_o.waddr     = pos_q[IDX_W-1:0];
        ram_req_o.wdata.key = key_q;
        ram_req_o.wdata.value = value_q;
        count_d = count_q + CNT_W'(1);
        state_d = S_DONE;
      end

      S_SHIFT_DN: begin
        // read slot sh, write it to slot sh-1 next cycle
        ram_req_o.raddr = sh_q[IDX_W-1:0];
        ram_req_o.we    = pend_q;
        issue = (sh_q < count_q);
        if (issue) begin
          pend_d     = 1'b1;
          pend_idx_d = sh_m1[IDX_W-1:0];
          sh_d       = sh_q + CNT_W'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            count_d = count_q - CNT_W'(1);
            state_d = S_DONE;
          end
        end
      end

      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_o.found       = found_q;
  assign res_o.value_out   = (action_q == vskt_pkg::ACT_LOOKUP && found_q) ?
                             hit_val_q : missing_value_i;
  assign res_o.status      = status_q;
  assign res_o.entry_count = vskt_pkg::OUT_CNT_W'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    action_q   <= action_d;
    key_q      <= key_d;
    value_q    <= value_d;
    hit_val_q  <= hit_val_d;
    idx_q      <= idx_d;
    pos_q      <= pos_d;
    sh_q       <= sh_d;
    pend_idx_q <= pend_idx_d;
    found_q    <= found_d;
    posf_q     <= posf_d;
    slot_q     <= slot_d;
    status_q   <= status_d;
  end

endmodule

// ===== rtl/value_sorted_key_table_core.sv =====
`timescale 1ns / 1ps
// Value-sorted key table: a fixed-capacity key/value table kept in descending
// order of value, with lookup, insert, delete and clear. An action first scans
// the occupied slots through one read port of the entry memory. An insert
// then moves the later entries up one slot per cycle and places the new pair.
// A delete moves the later entries down one slot per cycle. An insert only
// moves entries when count is below CAPACITY. The input is not ready while
// an action is in progress; a finished result sits in an output register, so
// the next transaction can start while it waits to be taken.
// Depends on vskt_pkg, vskt_if, vskt_ram and vskt_seq.
module value_sorted_key_table_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  vskt_in_if.sink                           in_i,
  vskt_out_if.source                        out_o,
  input  logic                              cfg_we_i,
  input  logic signed [vskt_pkg::VAL_W-1:0] cfg_wdata_i
);

  logic signed [vskt_pkg::VAL_W-1:0] missing_value_q;
  vskt_pkg::ram_req_t                ram_req;
  vskt_pkg::entry_t                  ram_rdata;
  logic                              res_valid;
  logic                              res_ready;
  vskt_pkg::result_t                 res;
  logic                              out_valid_q;
  vskt_pkg::result_t                 out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      missing_value_q <= -32'sd1;
    end else if (cfg_we_i) begin
      missing_value_q <= cfg_wdata_i;
    end
  end

  vskt_ram #(
    .Width(vskt_pkg::ENTRY_W),
    .Depth(vskt_pkg::CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_req.we),
    .waddr_i(ram_req.waddr),
    .wdata_i(ram_req.wdata),
    .raddr_i(ram_req.raddr),
    .rdata_o(ram_rdata)
  );

  vskt_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_i           (in_i),
    .missing_value_i(missing_value_q),
    .ram_req_o      (ram_req),
    .ram_rdata_i    (ram_rdata),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res)
  );

  // load the output register when it is empty or being drained
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.found       = out_data_q.found;
  assign out_o.value_out   = out_data_q.value_out;
  assign out_o.status      = out_data_q.status;
  assign out_o.entry_count = out_data_q.entry_count;

endmodule

// ===== verif/vskt_table_checker.sv =====
`timescale 1ns / 1ps
// Checker for the value-sorted key table. It watches the command, result and
// register ports, keeps a shadow copy of the table and compares each result.
// Depends on vskt_pkg and the channel interfaces in vskt_if.
module vskt_table_checker
  import vskt_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  vskt_in_if                      in_ch_i,
  vskt_out_if                     out_ch_i,
  input  logic                    cfg_we_i,
  input  logic signed [VAL_W-1:0] cfg_wdata_i,
  output int                      fail_count_o,
  output int                      pending_o
);

  logic [KEY_W-1:0]        shadow_keys [CAPACITY];
  logic signed [VAL_W-1:0] shadow_vals [CAPACITY];
  int                      shadow_fill;
  logic signed [VAL_W-1:0] miss_value;
  result_t                 expected_q [$];
  result_t                 want;

  // Apply one command to the shadow table and return the result it should produce.
  function automatic result_t apply_action(action_e act, logic [KEY_W-1:0] k,
                                           logic signed [VAL_W-1:0] v);
    result_t r;
    int      slot;
    int      pos;
    slot = shadow_fill;
    for (int i = shadow_fill - 1; i >= 0; i--)
      if (shadow_keys[i] == k) slot = i;
    r.found     = (slot < shadow_fill);
    r.value_out = miss_value;
    r.status    = ST_DONE;
    case (act)
      ACT_LOOKUP: begin
        if (r.found) r.value_out = shadow_vals[slot];
        else r.status = ST_ABSENT;
      end
      ACT_INSERT: begin
        if (r.found) begin
          r.status = ST_PRESENT;
        end else if (shadow_fill >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          // go in front of the first entry whose value is not greater
          pos = 0;
          while (pos < shadow_fill && v < shadow_vals[pos]) pos++;
          for (int i = shadow_fill; i > pos; i--) begin
            shadow_keys[i] = shadow_keys[i-1];
            shadow_vals[i] = shadow_vals[i-1];
          end
          shadow_keys[pos] = k;
          shadow_vals[pos] = v;
          shadow_fill++;
        end
      end
      ACT_DELETE: begin
        if (r.found) begin
          for (int i = slot; i + 1 < shadow_fill; i++) begin
            shadow_keys[i] = shadow_keys[i+1];
            shadow_vals[i] = shadow_vals[i+1];
          end
          shadow_fill--;
        end else begin
          r.status = ST_ABSENT;
        end
      end
      default: shadow_fill = 0;
    endcase
    r.entry_count = shadow_fill[OUT_CNT_W-1:0];
    return r;
  endfunction

  task automatic compare_field(string name, logic signed [63:0] want_v,
                               logic signed [63:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want_v, got_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_fill  = 0;
      miss_value   = -1;
      expected_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) miss_value = cfg_wdata_i;
      if (in_ch_i.valid && in_ch_i.ready)
        expected_q.push_back(apply_action(action_e'(in_ch_i.action), in_ch_i.key,
                                          in_ch_i.value));
      if (out_ch_i.valid && out_ch_i.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %0d %0d %0d %0d",
                   $time, out_ch_i.found, out_ch_i.value_out, out_ch_i.status,
                   out_ch_i.entry_count);
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          compare_field("found", 64'(want.found), 64'(out_ch_i.found));
          compare_field("value_out", 64'(want.value_out), 64'(out_ch_i.value_out));
          compare_field("status", 64'(want.status), 64'(out_ch_i.status));
          compare_field("entry_count", 64'(want.entry_count),
                        64'(out_ch_i.entry_count));
        end
      end
      pending_o = expected_q.size();
    end
  end

endmodule

// ===== verif/value_sorted_key_table_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the value-sorted key table: clock, reset, command and
// register stimulus, result-side stalls, watchdog and verdict.
// Depends on vskt_pkg, vskt_if, the core and vskt_table_checker.
module value_sorted_key_table_core_tb;
  import vskt_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 2 * CAPACITY + 50;
  localparam int POOL_SIZE      = 128;
  localparam int NUM_PHASES     = 8;
  localparam int PHASE_ITEMS    = 50;

  localparam int MODE_FILL  = 0;
  localparam int MODE_SHRINK = 1;
  localparam int MODE_MIXED = 2;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic signed [VAL_W-1:0] cfg_wdata_i;
  int                      fail_count;
  int                      pending;
  int                      idle_cycles = 0;
  bit                      no_idle = 1'b0;
  logic [KEY_W-1:0]        key_pool [POOL_SIZE];

  vskt_in_if  in_if ();
  vskt_out_if out_if ();

  value_sorted_key_table_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  vskt_table_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch_i      (in_if),
    .out_ch_i     (out_if),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #10 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 16);
    return $urandom_range(40, 200);
  endfunction

  // Leave valid high after the transaction so a back-to-back command needs no toggle.
  task automatic send_op(action_e act, logic [KEY_W-1:0] k, logic signed [VAL_W-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.action <= act;
    in_if.key    <= k;
    in_if.value  <= v;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_missing(logic signed [VAL_W-1:0] mv);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mv;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic random_item(int mode);
    int                      r;
    action_e                 act;
    logic [KEY_W-1:0]        k;
    logic signed [VAL_W-1:0] v;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_FILL: begin
        if (r < 80) act = ACT_INSERT;
        else if (r < 92) act = ACT_LOOKUP;
        else act = ACT_DELETE;
      end
      MODE_SHRINK: begin
        if (r < 20) act = ACT_INSERT;
        else if (r < 50) act = ACT_LOOKUP;
        else act = ACT_DELETE;
      end
      default: begin
        if (r < 40) act = ACT_INSERT;
        else if (r < 75) act = ACT_LOOKUP;
        else if (r < 96) act = ACT_DELETE;
        else act = ACT_CLEAR;
      end
    endcase
    if ($urandom_range(0, 9) == 0) k = KEY_W'($urandom);
    else k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    // a narrow value band makes ties common
    if ($urandom_range(0, 4) == 0) v = VAL_W'($urandom_range(0, 6)) - 3;
    else v = VAL_W'($urandom);
    send_op(act, k, v);
  endtask

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= 1'b1;
      repeat ($urandom_range(0, 8)) @(posedge clk_i);
      begin : stall_blk
        int stall;
        stall = pick_gap();
        if (stall > 0) begin
          out_if.ready <= 1'b0;
          repeat (stall - 1) @(posedge clk_i);
        end
      end
    end
  end

  // Abort if no transaction moves on either channel for too long.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int mode;
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.action = ACT_LOOKUP;
    in_if.key    = '0;
    in_if.value  = '0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = KEY_W'($urandom);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, extremes, ties, present key, hits and misses, clear
    send_op(ACT_LOOKUP, 16'h0000, 32'sd0);
    send_op(ACT_DELETE, 16'hFFFF, 32'sd0);
    send_op(ACT_INSERT, 16'h0000, 32'sh7FFF_FFFF);
    send_op(ACT_INSERT, 16'hFFFF, 32'sh8000_0000);
    send_op(ACT_INSERT, 16'h1234, 32'sd5);
    send_op(ACT_INSERT, 16'h4321, 32'sd5);
    send_op(ACT_INSERT, 16'h1234, 32'sd9);
    send_op(ACT_LOOKUP, 16'hFFFF, 32'sd0);
    send_op(ACT_LOOKUP, 16'h4321, 32'sd0);
    send_op(ACT_LOOKUP, 16'h0000, 32'sd0);
    send_op(ACT_DELETE, 16'h1234, 32'sd0);
    send_op(ACT_DELETE, 16'h1234, 32'sd0);
    send_op(ACT_LOOKUP, 16'h1234, 32'sd0);
    send_op(ACT_INSERT, 16'hAAAA, 32'sh8000_0000);
    send_op(ACT_LOOKUP, 16'h5555, 32'sd0);
    send_op(ACT_CLEAR,  16'hFFFF, 32'sd0);
    send_op(ACT_CLEAR,  16'h0000, 32'sd0);
    send_op(ACT_LOOKUP, 16'hFFFF, 32'sd0);
    send_op(ACT_INSERT, 16'h8001, 32'sh7FFF_FFFF);
    send_op(ACT_LOOKUP, 16'h8001, 32'sd0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: write_missing(32'sh8000_0000);
        1: write_missing(32'sh7FFF_FFFF);
        2: write_missing(32'sd0);
        3: write_missing(-32'sd1);
        default: write_missing(VAL_W'($urandom));
      endcase
      no_idle = (p == 2 || p == 5);
      case (p % 4)
        0, 1: mode = MODE_FILL;
        2: mode = MODE_MIXED;
        default: mode = MODE_SHRINK;
      endcase
      repeat (PHASE_ITEMS) random_item(mode);
    end
    no_idle = 1'b0;

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
